// ----- rtl/mac_address_reservation_table_unit_assert.svh -----
`ifndef MAC_ADDRESS_RESERVATION_TABLE_UNIT_ASSERT_SVH
`define MAC_ADDRESS_RESERVATION_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MATRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrt assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define MATRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrt assertion failed");

`endif

// ----- rtl/matrt_pkg.sv -----
package matrt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;

  localparam int unsigned MAC_W      = 48;
  localparam int unsigned OCT_W      = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CNT_OUT_W  = 6;
  localparam int unsigned ENTRY_W    = MAC_W + OCT_W;
  localparam int unsigned MCAST_BIT  = 40;

  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned CHUNK_SEL_W = OCT_W - $clog2(CHUNK_W);
  localparam int unsigned CHUNK_OFF_W = $clog2(CHUNK_W);
  localparam int unsigned OCT_NUM     = 1 << OCT_W;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [OCT_W-1:0] BAND_LOW_RST  = 8'd2;
  localparam logic [OCT_W-1:0] BAND_HIGH_RST = 8'd99;

  typedef enum logic [OP_W-1:0] {
    OP_UPSERT,
    OP_REMOVE,
    OP_FIND,
    OP_NEXT_FREE
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_BAD_MAC,
    STAT_BAD_OCTET,
    STAT_DUP_OCTET,
    STAT_NOT_FOUND
  } status_e;

  typedef enum logic {
    REG_BAND_LOW,
    REG_BAND_HIGH
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RM_RD,
    S_RM_WR,
    S_FREE
  } fsm_e;

  typedef struct packed {
    logic             clear;
    logic             mark;
    logic [OCT_W-1:0] octet;
    logic             start;
  } frs_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [OCT_W-1:0] octet;
  } frs_stat_t;

endpackage

// ----- rtl/mac_address_reservation_table_unit.sv -----
// channel   direction  handshake                         payload
// command   in         start_i, busy_o                   op_i, mac_addr_i, host_octet_i
// result    out        done_o (one-cycle strobe)         status_o, octet_out_o, entry_count_o
// config    in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// an item is taken when start_i is high and busy_o low; one result per item
// upsert with a bad mac or octet answers straight from idle; others scan the used
// entries through the table ram, one per cycle, then decide in S_DECIDE
// a remove that finds its entry then moves the last entry into its slot (S_RM_RD, S_RM_WR)
// next free then searches the band, 16 octets checked per cycle against the scan
// the receiver cannot stall; rst_ni empties the table and restores the band
`include "mac_address_reservation_table_unit_assert.svh"

module mac_address_reservation_table_unit import matrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [MAC_W-1:0]      mac_addr_i,
  input  logic [OCT_W-1:0]      host_octet_i,
  output logic                  done_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [OCT_W-1:0]      octet_out_o,
  output logic [CNT_OUT_W-1:0]  entry_count_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  fsm_e             state_q, state_d;
  op_e              op_q, op_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic [OCT_W-1:0] oct_q, oct_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    iss_q, iss_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic             found_q, found_d;
  logic [AW-1:0]    found_idx_q, found_idx_d;
  logic [OCT_W-1:0] found_oct_q, found_oct_d;
  logic             dup_q, dup_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [OCT_W-1:0] octo_q, octo_d;
  logic [OCT_W-1:0] band_low_q, band_high_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [MAC_W-1:0]   rd_mac;
  logic [OCT_W-1:0]   rd_oct;
  logic               rd_match;
  logic [CW-1:0]      last;

  frs_ctrl_t frs_ctrl;
  frs_stat_t frs_stat;

  logic             accept;
  logic             bad_mac, bad_oct;
  logic             cfg_wr;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  assign bad_mac = (mac_addr_i == '0) || (mac_addr_i == '1) || mac_addr_i[MCAST_BIT];
  assign bad_oct = (host_octet_i < band_low_q) || (host_octet_i > band_high_q);

  assign rd_mac   = ram_rdata[ENTRY_W-1:OCT_W];
  assign rd_oct   = ram_rdata[OCT_W-1:0];
  assign rd_match = (rd_mac == mac_q);
  assign last     = count_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    mac_d       = mac_q;
    oct_d       = oct_q;
    count_d     = count_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_oct_d = found_oct_q;
    dup_d       = dup_q;
    done_d      = 1'b0;
    status_d    = status_q;
    octo_d      = octo_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {mac_q, oct_q};
    ram_re      = 1'b0;
    ram_raddr   = '0;
    frs_ctrl    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d           = op_e'(op_i);
          mac_d          = mac_addr_i;
          oct_d          = host_octet_i;
          iss_d          = '0;
          found_d        = 1'b0;
          dup_d          = 1'b0;
          frs_ctrl.clear = 1'b1;
          if (op_e'(op_i) == OP_UPSERT && (bad_mac || bad_oct)) begin
            done_d   = 1'b1;
            status_d = bad_mac ? STAT_BAD_MAC : STAT_BAD_OCTET;
            octo_d   = '0;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (iss_q < count_q) begin
          ram_re     = 1'b1;
          ram_raddr  = iss_q[AW-1:0];
          iss_d      = iss_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = iss_q[AW-1:0];
        end
        if (pend_q) begin
          frs_ctrl.mark  = 1'b1;
          frs_ctrl.octet = rd_oct;
          if (rd_match && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = pend_idx_q;
            found_oct_d = rd_oct;
          end
          if (!rd_match && rd_oct == oct_q) begin
            dup_d = 1'b1;
          end
        end
        if ((iss_q == count_q) && (pend_q || count_q == '0)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (op_q)
          OP_UPSERT: begin
            octo_d = '0;
            if (dup_q) begin
              status_d = STAT_DUP_OCTET;
            end else if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = found_idx_q;
              status_d  = STAT_OK;
            end else if (count_q == CW'(TABLE_DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              count_d   = count_q + 1'b1;
              status_d  = STAT_OK;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          OP_REMOVE: begin
            if (found_q) begin
              state_d = S_RM_RD;
            end else begin
              status_d = STAT_NOT_FOUND;
              octo_d   = '0;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end
          end
          OP_FIND: begin
            status_d = found_q ? STAT_OK : STAT_NOT_FOUND;
            octo_d   = found_q ? found_oct_q : '0;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
          OP_NEXT_FREE: begin
            frs_ctrl.start = 1'b1;
            state_d        = S_FREE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = last[AW-1:0];
        state_d   = S_RM_WR;
      end

      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = found_idx_q;
        ram_wdata = ram_rdata;
        count_d   = last;
        status_d  = STAT_OK;
        octo_d    = '0;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_FREE: begin
        if (frs_stat.done) begin
          status_d = STAT_OK;
          octo_d   = frs_stat.octet;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      dup_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      dup_q   <= dup_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    mac_q       <= mac_d;
    oct_q       <= oct_d;
    pend_idx_q  <= pend_idx_d;
    found_idx_q <= found_idx_d;
    found_oct_q <= found_oct_d;
    status_q    <= status_d;
    octo_q      <= octo_d;
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_BAND_LOW:  band_low_q  <= pwdata[OCT_W-1:0];
        REG_BAND_HIGH: band_high_q <= pwdata[OCT_W-1:0];
        default: begin
          band_low_q <= band_low_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_BAND_LOW:  prdata = APB_DATA_W'(band_low_q);
      REG_BAND_HIGH: prdata = APB_DATA_W'(band_high_q);
      default:       prdata = '0;
    endcase
  end

  matrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  matrt_free_search u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (frs_ctrl),
    .band_low_i  (band_low_q),
    .band_high_i (band_high_q),
    .stat_o      (frs_stat)
  );

  assign cnt_ext       = {{CNT_OUT_W{1'b0}}, count_q};
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign octet_out_o   = octo_q;
  assign entry_count_o = cnt_ext[CNT_OUT_W-1:0];

  `MATRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH))
  `MATRT_ASSERT_NOW(a_done_idle, done_o, !busy_o)
  `MATRT_ASSERT_NOW(a_write_state, ram_we, (state_q == S_DECIDE) || (state_q == S_RM_WR))
  `MATRT_ASSERT_NEXT(a_accept_moves, start_i && !busy_o, done_o || busy_o)

endmodule

// ----- rtl/matrt_ram.sv -----
module matrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/matrt_free_search.sv -----
module matrt_free_search import matrt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frs_ctrl_t        ctrl_i,
  input  logic [OCT_W-1:0] band_low_i,
  input  logic [OCT_W-1:0] band_high_i,
  output frs_stat_t        stat_o
);

  logic [OCT_NUM-1:0]     held_q, held_d;
  logic [CHUNK_SEL_W-1:0] chunk_q, chunk_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [OCT_W-1:0]       res_q, res_d;
  logic [CHUNK_W-1:0]     cand;
  logic [CHUNK_OFF_W-1:0] first;
  logic [OCT_W-1:0]       oct_j;

  // free octets of the current chunk that lie in the band
  always_comb begin
    cand  = '0;
    first = '0;
    oct_j = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      oct_j   = {chunk_q, CHUNK_OFF_W'(j)};
      cand[j] = !held_q[oct_j] && (oct_j >= band_low_i) && (oct_j <= band_high_i);
    end
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        first = CHUNK_OFF_W'(j);
      end
    end
  end

  always_comb begin
    held_d  = held_q;
    chunk_d = chunk_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    res_d   = res_q;
    if (ctrl_i.clear) begin
      held_d = '0;
    end else if (ctrl_i.mark) begin
      held_d[ctrl_i.octet] = 1'b1;
    end
    if (ctrl_i.start) begin
      if (band_low_i > band_high_i) begin
        done_d = 1'b1;
        res_d  = '0;
      end else begin
        busy_d  = 1'b1;
        chunk_d = band_low_i[OCT_W-1:CHUNK_OFF_W];
      end
    end else if (busy_q) begin
      if (|cand) begin
        done_d = 1'b1;
        busy_d = 1'b0;
        res_d  = {chunk_q, first};
      end else if (chunk_q == band_high_i[OCT_W-1:CHUNK_OFF_W]) begin
        done_d = 1'b1;
        busy_d = 1'b0;
        res_d  = '0;
      end else begin
        chunk_d = chunk_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      chunk_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      chunk_q <= chunk_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.octet = res_q;

endmodule

// ----- tb/sv/mac_address_reservation_table_unit_tb.sv -----
module mac_address_reservation_table_unit_tb;
  import matrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = TABLE_DEPTH_DEF;
  localparam int MAC_POOL = 40;
  localparam int LIMIT_CYCLES = 1_000_000;

  localparam logic [MAC_W-1:0] MAC_A       = 48'h02_11_22_33_44_55;
  localparam logic [MAC_W-1:0] MAC_B       = 48'h0A_00_00_00_00_01;
  localparam logic [MAC_W-1:0] MAC_C       = 48'h3C_5A_A5_00_FF_10;
  localparam logic [MAC_W-1:0] MAC_D       = 48'h66_01_02_03_04_05;
  localparam logic [MAC_W-1:0] MAC_MCAST   = 48'h01_00_5E_00_00_FB;
  localparam logic [MAC_W-1:0] MAC_TOP_UNI = 48'hFE_FF_FF_FF_FF_FF;

  typedef struct packed {
    status_e              status;
    logic [OCT_W-1:0]     octet;
    logic [CNT_OUT_W-1:0] count;
  } reservation_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [OP_W-1:0]       op_i;
  logic [MAC_W-1:0]      mac_addr_i;
  logic [OCT_W-1:0]      host_octet_i;
  logic                  done_o;
  logic [STAT_W-1:0]     status_o;
  logic [OCT_W-1:0]      octet_out_o;
  logic [CNT_OUT_W-1:0]  entry_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [MAC_W-1:0] shadow_mac [SLOTS];
  logic [OCT_W-1:0] shadow_octet [SLOTS];
  int               shadow_used;
  logic [OCT_W-1:0] band_lo;
  logic [OCT_W-1:0] band_hi;
  logic [MAC_W-1:0] mac_pool [MAC_POOL];

  reservation_t awaited_replies [$];
  int errors;
  int words_issued;
  int results_checked;
  int band_settings;
  int status_tally [8];
  int cycle_count;

  mac_address_reservation_table_unit #(
    .TABLE_DEPTH(SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .mac_addr_i   (mac_addr_i),
    .host_octet_i (host_octet_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .octet_out_o  (octet_out_o),
    .entry_count_o(entry_count_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_slot(logic [MAC_W-1:0] mac);
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic bit octet_taken(logic [OCT_W-1:0] oct, bit skip_own,
                                     logic [MAC_W-1:0] own_mac);
    for (int i = 0; i < shadow_used; i++) begin
      if (!(skip_own && shadow_mac[i] == own_mac) && shadow_octet[i] == oct) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic reservation_t predict_reservation(op_e op, logic [MAC_W-1:0] mac,
                                                       logic [OCT_W-1:0] oct);
    reservation_t res;
    int slot;
    bit found;
    res.status = STAT_OK;
    res.octet = '0;
    found = 1'b0;
    case (op)
      OP_UPSERT: begin
        if (mac == '0 || mac == '1 || mac[MCAST_BIT]) begin
          res.status = STAT_BAD_MAC;
        end else if (oct < band_lo || oct > band_hi) begin
          res.status = STAT_BAD_OCTET;
        end else if (octet_taken(oct, 1'b1, mac)) begin
          res.status = STAT_DUP_OCTET;
        end else begin
          slot = find_slot(mac);
          if (slot >= 0) begin
            shadow_octet[slot] = oct;
          end else if (shadow_used >= SLOTS) begin
            res.status = STAT_FULL;
          end else begin
            shadow_mac[shadow_used] = mac;
            shadow_octet[shadow_used] = oct;
            shadow_used++;
          end
        end
      end
      OP_REMOVE: begin
        slot = find_slot(mac);
        if (slot >= 0) begin
          shadow_mac[slot] = shadow_mac[shadow_used-1];
          shadow_octet[slot] = shadow_octet[shadow_used-1];
          shadow_used--;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      OP_FIND: begin
        slot = find_slot(mac);
        if (slot >= 0) res.octet = shadow_octet[slot];
        else res.status = STAT_NOT_FOUND;
      end
      default: begin
        for (int o = int'(band_lo); o <= int'(band_hi) && !found; o++) begin
          if (!octet_taken(OCT_W'(o), 1'b0, '0)) begin
            res.octet = OCT_W'(o);
            found = 1'b1;
          end
        end
      end
    endcase
    res.count = CNT_OUT_W'(shadow_used);
    return res;
  endfunction

  // start_i stays high after acceptance so the next word can follow back to back
  task automatic issue_word(op_e op, logic [MAC_W-1:0] mac, logic [OCT_W-1:0] oct);
    start_i <= 1'b1;
    op_i <= op;
    mac_addr_i <= mac;
    host_octet_i <= oct;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    awaited_replies.push_back(predict_reservation(op, mac, oct));
    words_issued++;
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [OCT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
  endtask

  task automatic set_band(logic [OCT_W-1:0] lo, logic [OCT_W-1:0] hi);
    settle();
    write_reg(REG_BAND_LOW, lo);
    write_reg(REG_BAND_HIGH, hi);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    band_lo = lo;
    band_hi = hi;
    band_settings++;
  endtask

  // pool macs mostly, with zero, broadcast, multicast and raw noise mixed in
  task automatic run_random(int words, int upsert_pct, int remove_pct);
    int burst;
    int pick;
    op_e op;
    logic [MAC_W-1:0] mac;
    logic [OCT_W-1:0] oct;
    burst = 0;
    for (int n = 0; n < words; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (n != 0 && $urandom_range(0, 3) != 0) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < upsert_pct) op = OP_UPSERT;
      else if (pick < upsert_pct + remove_pct) op = OP_REMOVE;
      else if ($urandom_range(0, 1) == 0) op = OP_FIND;
      else op = OP_NEXT_FREE;
      case ($urandom_range(0, 19))
        0: mac = '0;
        1: mac = '1;
        2: begin
          mac = MAC_W'({$urandom, $urandom});
          mac[MCAST_BIT] = 1'b1;
        end
        3: mac = MAC_W'({$urandom, $urandom});
        default: mac = mac_pool[$urandom_range(0, MAC_POOL-1)];
      endcase
      if ($urandom_range(0, 4) != 0) oct = OCT_W'($urandom_range(band_hi, band_lo));
      else oct = OCT_W'($urandom_range(0, 255));
      issue_word(op, mac, oct);
    end
  endtask

  task automatic test_directed_ops();
    issue_word(OP_NEXT_FREE, MAC_A, 8'd0);
    issue_word(OP_FIND, MAC_A, 8'd0);
    issue_word(OP_REMOVE, MAC_A, 8'd0);
    issue_word(OP_UPSERT, '0, 8'd0);
    issue_word(OP_UPSERT, '1, 8'd50);
    issue_word(OP_UPSERT, MAC_MCAST, 8'd50);
    issue_word(OP_UPSERT, MAC_A, 8'd1);
    issue_word(OP_UPSERT, MAC_A, 8'd100);
    issue_word(OP_UPSERT, MAC_A, 8'd2);
    issue_word(OP_UPSERT, MAC_B, 8'd99);
    issue_word(OP_UPSERT, MAC_B, 8'd2);
    issue_word(OP_UPSERT, MAC_A, 8'd50);
    issue_word(OP_NEXT_FREE, MAC_A, 8'd0);
    issue_word(OP_FIND, MAC_A, 8'd0);
    issue_word(OP_UPSERT, MAC_TOP_UNI, 8'd3);
    issue_word(OP_REMOVE, MAC_A, 8'd0);
    issue_word(OP_REMOVE, MAC_B, 8'd0);
    issue_word(OP_REMOVE, MAC_TOP_UNI, 8'd0);
  endtask

  task automatic test_band_special_cases();
    // octet zero reservable and reported as next free
    set_band(8'd0, 8'd255);
    issue_word(OP_NEXT_FREE, MAC_A, 8'd0);
    issue_word(OP_UPSERT, MAC_A, 8'd0);
    issue_word(OP_FIND, MAC_A, 8'd0);
    issue_word(OP_UPSERT, MAC_B, 8'd255);
    // top of band scanned inclusively, no wrap
    set_band(8'd254, 8'd255);
    issue_word(OP_UPSERT, MAC_C, 8'd254);
    issue_word(OP_NEXT_FREE, MAC_A, 8'd0);
    issue_word(OP_REMOVE, MAC_B, 8'd0);
    issue_word(OP_NEXT_FREE, MAC_A, 8'd0);
    // inverted band
    set_band(8'd200, 8'd100);
    issue_word(OP_UPSERT, MAC_D, 8'd150);
    issue_word(OP_NEXT_FREE, MAC_D, 8'd0);
  endtask

  task automatic test_fill_to_capacity();
    set_band(BAND_LOW_RST, BAND_HIGH_RST);
    run_random(300, 70, 10);
  endtask

  task automatic test_wide_band();
    set_band(8'd0, 8'd255);
    run_random(250, 50, 25);
  endtask

  task automatic test_narrow_band_from_zero();
    set_band(8'd0, 8'd20);
    run_random(250, 45, 25);
  endtask

  task automatic test_top_of_band();
    set_band(8'd240, 8'd255);
    run_random(250, 45, 25);
  endtask

  task automatic test_inverted_band();
    set_band(8'd100, 8'd50);
    run_random(150, 40, 30);
  endtask

  task automatic test_single_octet_bands();
    set_band(8'd0, 8'd0);
    run_random(75, 45, 25);
    set_band(8'd255, 8'd255);
    run_random(75, 45, 25);
  endtask

  task automatic test_drain_table();
    set_band(8'd10, 8'd200);
    run_random(300, 30, 45);
  endtask

  always @(posedge clk_i) begin
    reservation_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d octet %0d count %0d",
                 $time, status_o, octet_out_o, entry_count_o);
      end else begin
        want = awaited_replies.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (octet_out_o !== want.octet) begin
          errors++;
          $display("%0t: octet expected %0d actual %0d", $time, want.octet, octet_out_o);
        end
        if (entry_count_o !== want.count) begin
          errors++;
          $display("%0t: entry count expected %0d actual %0d",
                   $time, want.count, entry_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("mac_address_reservation_table_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    op_i <= OP_UPSERT;
    mac_addr_i <= '0;
    host_octet_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    shadow_used = 0;
    band_lo = BAND_LOW_RST;
    band_hi = BAND_HIGH_RST;
    for (int i = 0; i < MAC_POOL; i++) begin
      mac_pool[i] = MAC_W'({$urandom, $urandom});
      mac_pool[i][MCAST_BIT] = 1'b0;
      if (mac_pool[i] == '0) mac_pool[i][0] = 1'b1;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_band_special_cases();
    test_fill_to_capacity();
    test_wide_band();
    test_narrow_band_from_zero();
    test_top_of_band();
    test_inverted_band();
    test_single_octet_bands();
    test_drain_table();

    settle();
    repeat (60) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      errors += awaited_replies.size();
      $display("%0t: %0d results never arrived", $time, awaited_replies.size());
    end
    $display("run covered %0d words over %0d band settings, %0d results checked",
             words_issued, band_settings, results_checked);
    $display("ok %0d, full %0d, bad mac %0d, bad octet %0d, duplicate %0d, not found %0d",
             status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_BAD_MAC],
             status_tally[STAT_BAD_OCTET], status_tally[STAT_DUP_OCTET],
             status_tally[STAT_NOT_FOUND]);
    if (errors == 0) begin
      $display("mac_address_reservation_table_unit_tb: clean");
    end else begin
      $display("mac_address_reservation_table_unit_tb: errors");
    end
    $finish;
  end

endmodule
